// ===== hw/rtl/ptpp_pkg.sv =====
package ptpp_pkg;

	localparam int MAX_VERTICES_DEF = 64;

	localparam int OP_W     = 2;
	localparam int COORD_W  = 24;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int DIST_W   = 25;
	localparam int PROG_W   = 32;
	localparam int RATIO_W  = 24;
	localparam int LEN2_W   = 50;
	localparam int DOT_W    = 51;
	localparam int MUL_W    = 26;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int D2_W     = 64;
	localparam int ROOT_W   = 32;
	localparam int SEGLEN_W = 25;
	localparam int MAG_W    = 34;
	localparam int HALF_W   = 17;
	localparam int FRAC_W   = 16;
	localparam int CNT_W    = 6;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic [RATIO_W-1:0] RATIO_ONE = 24'h010000;
	localparam logic [RATIO_W-1:0] RATIO_MAX = 24'hFFFFFF;
	localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
	localparam logic [PROG_W-1:0]  PROG_MAX  = '1;

	typedef struct packed {
		logic start;
		logic sqrt;
	} iter_ctl_t;

endpackage

// ===== hw/rtl/point_to_polyline_projection.sv =====
// Point-to-polyline projection.
// A request is taken when start is high and busy is low. op selects the
// command: clear the vertex store, append one vertex, or project the point
// (coord_x, coord_y) onto the stored polyline. Clear and append finish in
// the cycle they are taken and give no result; an unused op code is dropped.
// A projection walks the segments one at a time through a single 26x26
// multiplier and one shared compare-subtract unit that does both the ratio
// division (24 steps) and the floored square roots (32 steps each). With
// fewer than two vertices the query goes straight to the output state and
// finds nothing. Otherwise each segment has its squared length and dot
// product formed, the ratio divided out unless it clamps, then the squared
// distance and the segment length root; a degenerate segment is skipped.
// The best distance, if any, gets its root last. busy stays high until
// the result appears. The result is shown for one cycle with done high and
// is not held back: the receiver cannot stall it. Reset clears the vertex
// count and the sequencer; the vertex contents stay unknown until written.
module point_to_polyline_projection import ptpp_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [OP_W-1:0]           op,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	output logic                      done,
	output logic                      found,
	output logic [DIST_W-1:0]         distance,
	output logic [PROG_W-1:0]         progress
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);

	typedef enum logic [22:0] {
		S_IDLE = 23'b1 << 0,
		S_RDA  = 23'b1 << 1,
		S_LDA  = 23'b1 << 2,
		S_RDB  = 23'b1 << 3,
		S_LDB  = 23'b1 << 4,
		S_L2A  = 23'b1 << 5,
		S_L2B  = 23'b1 << 6,
		S_DTA  = 23'b1 << 7,
		S_DTB  = 23'b1 << 8,
		S_CHK  = 23'b1 << 9,
		S_DEC  = 23'b1 << 10,
		S_DIV  = 23'b1 << 11,
		S_OFX  = 23'b1 << 12,
		S_OFY  = 23'b1 << 13,
		S_EY   = 23'b1 << 14,
		S_SQ   = 23'b1 << 15,
		S_SQL  = 23'b1 << 16,
		S_UPD  = 23'b1 << 17,
		S_PRG  = 23'b1 << 18,
		S_NXT  = 23'b1 << 19,
		S_FIN  = 23'b1 << 20,
		S_SQD  = 23'b1 << 21,
		S_OUT  = 23'b1 << 22
	} state_t;

	state_t state_q;

	logic [CW-1:0]              cnt_q;
	logic [AW-1:0]              idx_q;
	logic signed [COORD_W-1:0]  px_q, py_q, ax_q, ay_q, bx_q, by_q;
	logic signed [DIFF_W-1:0]   dx_q, dy_q, rx_q, ry_q;
	logic [LEN2_W-1:0]          len2_q;
	logic signed [DOT_W-1:0]    dot_q;
	logic [RATIO_W-1:0]         ratio_q;
	logic [MAG_W-1:0]           exm_q, eym_q;
	logic [D2_W-1:0]            d2_q, best_d2_q;
	logic [PROG_W-1:0]          best_prog_q, acc_q;
	logic [SEGLEN_W-1:0]        seglen_q;
	logic                       best_found_q;
	logic                       last_q;
	logic [2:0]                 sq_k_q;
	logic                       done_q, found_q;
	logic [DIST_W-1:0]          distance_q;
	logic [PROG_W-1:0]          progress_q;

	logic                       accept;
	logic                       mem_we;
	logic [AW-1:0]              raddr;
	logic signed [COORD_W-1:0]  rd_x, rd_y;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [PROD_W-1:0]   p_q;
	iter_ctl_t                  ictl;
	logic [D2_W-1:0]            iopnd;
	logic                       irun;
	logic [ROOT_W-1:0]          ires;
	logic [MAG_W-1:0]           sq_val;
	logic [D2_W-1:0]            d2_add;
	logic signed [DIFF_W-1:0]   err_base;
	logic signed [36:0]         err_full;
	logic [36:0]                err_abs;
	logic [CW:0]                idx_nxt;
	logic                       dot_pos;
	logic                       better;
	logic [PROG_W:0]            acc_sum;
	logic [PROG_W-1:0]          acc_next;
	logic [36:0]                prog_sum;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign mem_we = accept && (op == OP_APPEND) && (cnt_q < CW'(MAX_VERTICES));
	assign raddr  = (state_q == S_RDA) ? '0 : idx_q;

	ptpp_vstore #(
		.MAX_VERTICES (MAX_VERTICES),
		.AW           (AW)
	) u_vstore (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wx    (coord_x),
		.wy    (coord_y),
		.raddr (raddr),
		.rx_q  (rd_x),
		.ry_q  (rd_y)
	);

	assign sq_val = (sq_k_q < 3'd3) ? exm_q : eym_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_L2A: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			S_L2B: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			S_DTA: begin
				mul_a = MUL_W'(rx_q);
				mul_b = MUL_W'(dx_q);
			end
			S_DTB: begin
				mul_a = MUL_W'(ry_q);
				mul_b = MUL_W'(dy_q);
			end
			S_OFX: begin
				mul_a = $signed({2'b0, ratio_q});
				mul_b = MUL_W'(dx_q);
			end
			S_OFY: begin
				mul_a = $signed({2'b0, ratio_q});
				mul_b = MUL_W'(dy_q);
			end
			S_UPD: begin
				mul_a = $signed({2'b0, ratio_q});
				mul_b = $signed({1'b0, seglen_q});
			end
			S_SQ: begin
				case (sq_k_q) inside
					3'd0, 3'd3: begin
						mul_a = $signed({9'b0, sq_val[HALF_W-1:0]});
						mul_b = $signed({9'b0, sq_val[HALF_W-1:0]});
					end
					3'd1, 3'd4: begin
						mul_a = $signed({9'b0, sq_val[MAG_W-1:HALF_W]});
						mul_b = $signed({9'b0, sq_val[HALF_W-1:0]});
					end
					3'd2, 3'd5: begin
						mul_a = $signed({9'b0, sq_val[MAG_W-1:HALF_W]});
						mul_b = $signed({9'b0, sq_val[MAG_W-1:HALF_W]});
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ptpp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	always_comb begin
		case (sq_k_q) inside
			3'd1, 3'd4: d2_add = {12'b0, p_q};
			3'd2, 3'd5: d2_add = {12'b0, p_q} << 18;
			3'd3, 3'd6: d2_add = {12'b0, p_q} << MAG_W;
			default:    d2_add = '0;
		endcase
	end

	always_comb begin
		err_base = (state_q == S_EY) ? ry_q : rx_q;
		err_full = 37'(err_base) - 37'($signed(p_q[PROD_W-1:FRAC_W]));
		err_abs  = err_full[36] ? (37'd0 - err_full) : err_full;
	end

	assign dot_pos  = !dot_q[DOT_W-1] && (dot_q != '0);
	assign idx_nxt  = (CW+1)'(idx_q) + (CW+1)'(1);
	assign better   = !best_found_q || (d2_q < best_d2_q);
	assign acc_sum  = {1'b0, acc_q} + (PROG_W+1)'(seglen_q);
	assign acc_next = acc_sum[PROG_W] ? PROG_MAX : acc_sum[PROG_W-1:0];
	assign prog_sum = 37'(acc_q) + 37'(p_q[PROD_W-1:FRAC_W]);

	always_comb begin
		ictl.start = 1'b0;
		ictl.sqrt  = 1'b0;
		iopnd      = best_d2_q;
		unique case (state_q)
			S_DEC: begin
				ictl.start = (len2_q != '0) && dot_pos && !(last_q
					? ({8'b0, dot_q[DOT_W-2:0]} >= {len2_q, 8'b0})
					: (dot_q[DOT_W-2:0] >= len2_q));
				iopnd = D2_W'(dot_q[DOT_W-2:0]);
			end
			S_SQ: begin
				ictl.start = (sq_k_q == 3'd6);
				ictl.sqrt  = 1'b1;
				iopnd      = D2_W'(len2_q);
			end
			S_FIN: begin
				ictl.start = best_found_q;
				ictl.sqrt  = 1'b1;
			end
			default: begin
				ictl.start = 1'b0;
			end
		endcase
	end

	ptpp_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ictl),
		.opnd    (iopnd),
		.divisor (len2_q),
		.run     (irun),
		.res     (ires)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			done_q       <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept && (op == OP_CLEAR)) begin
				cnt_q <= '0;
			end
			if (mem_we) begin
				cnt_q <= cnt_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_QUERY)) begin
						best_found_q <= 1'b0;
						state_q      <= (cnt_q < CW'(2)) ? S_OUT : S_RDA;
					end
				end
				S_RDA: state_q <= S_LDA;
				S_LDA: state_q <= S_RDB;
				S_RDB: state_q <= S_LDB;
				S_LDB: state_q <= S_L2A;
				S_L2A: state_q <= S_L2B;
				S_L2B: state_q <= S_DTA;
				S_DTA: state_q <= S_DTB;
				S_DTB: state_q <= S_CHK;
				S_CHK: state_q <= S_DEC;
				S_DEC: begin
					if (len2_q == '0) begin
						state_q <= S_NXT;
					end else if (ictl.start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_OFX;
					end
				end
				S_DIV: begin
					if (!irun) begin
						state_q <= S_OFX;
					end
				end
				S_OFX: state_q <= S_OFY;
				S_OFY: state_q <= S_EY;
				S_EY:  state_q <= S_SQ;
				S_SQ: begin
					if (sq_k_q == 3'd6) begin
						state_q <= S_SQL;
					end
				end
				S_SQL: begin
					if (!irun) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: state_q <= better ? S_PRG : S_NXT;
				S_PRG: begin
					best_found_q <= 1'b1;
					state_q      <= S_NXT;
				end
				S_NXT: state_q <= (idx_nxt < (CW+1)'(cnt_q)) ? S_RDB : S_FIN;
				S_FIN: state_q <= best_found_q ? S_SQD : S_OUT;
				S_SQD: begin
					if (!irun) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				px_q <= coord_x;
				py_q <= coord_y;
			end
			S_LDA: begin
				ax_q  <= rd_x;
				ay_q  <= rd_y;
				idx_q <= AW'(1);
				acc_q <= '0;
			end
			S_LDB: begin
				bx_q   <= rd_x;
				by_q   <= rd_y;
				dx_q   <= DIFF_W'(rd_x) - DIFF_W'(ax_q);
				dy_q   <= DIFF_W'(rd_y) - DIFF_W'(ay_q);
				rx_q   <= DIFF_W'(px_q) - DIFF_W'(ax_q);
				ry_q   <= DIFF_W'(py_q) - DIFF_W'(ay_q);
				last_q <= (idx_nxt == (CW+1)'(cnt_q));
			end
			S_L2B: len2_q <= p_q[LEN2_W-1:0];
			S_DTA: len2_q <= len2_q + p_q[LEN2_W-1:0];
			S_DTB: dot_q  <= p_q[DOT_W-1:0];
			S_CHK: dot_q  <= dot_q + p_q[DOT_W-1:0];
			S_DEC: begin
				if (!dot_pos) begin
					ratio_q <= '0;
				end else if (last_q) begin
					ratio_q <= RATIO_MAX;
				end else begin
					ratio_q <= RATIO_ONE;
				end
			end
			S_DIV: begin
				if (!irun) begin
					ratio_q <= ires[RATIO_W-1:0];
				end
			end
			S_OFY: exm_q <= err_abs[MAG_W-1:0];
			S_EY: begin
				eym_q  <= err_abs[MAG_W-1:0];
				d2_q   <= '0;
				sq_k_q <= '0;
			end
			S_SQ: begin
				d2_q <= d2_q + d2_add;
				if (sq_k_q != 3'd6) begin
					sq_k_q <= sq_k_q + 3'd1;
				end
			end
			S_SQL: begin
				if (!irun) begin
					seglen_q <= ires[SEGLEN_W-1:0];
				end
			end
			S_UPD: begin
				if (!better) begin
					acc_q <= acc_next;
				end
			end
			S_PRG: begin
				best_d2_q   <= d2_q;
				best_prog_q <= (prog_sum[36:PROG_W] != '0) ? PROG_MAX
					: prog_sum[PROG_W-1:0];
				acc_q       <= acc_next;
			end
			S_NXT: begin
				ax_q  <= bx_q;
				ay_q  <= by_q;
				idx_q <= idx_q + AW'(1);
			end
			S_OUT: begin
				found_q <= best_found_q;
				if (best_found_q) begin
					distance_q <= (ires[ROOT_W-1:DIST_W] != '0) ? DIST_MAX
						: ires[DIST_W-1:0];
					progress_q <= best_prog_q;
				end else begin
					distance_q <= '0;
					progress_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign done     = done_q;
	assign found    = found_q;
	assign distance = distance_q;
	assign progress = progress_q;

endmodule

// ===== hw/rtl/ptpp_iter.sv =====
module ptpp_iter import ptpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  iter_ctl_t         ctl,
	input  logic [D2_W-1:0]   opnd,
	input  logic [LEN2_W-1:0] divisor,
	output logic              run,
	output logic [ROOT_W-1:0] res
);

	logic [LEN2_W-1:0] rem_q;
	logic [D2_W-1:0]   sh_q;
	logic [ROOT_W-1:0] res_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sq_q;
	logic [LEN2_W:0]   a;
	logic [LEN2_W-1:0] b;
	logic [LEN2_W+1:0] diff;
	logic              ge;

	always_comb begin
		if (sq_q) begin
			a = {15'b0, rem_q[MAG_W-1:0], sh_q[D2_W-1 -: 2]};
			b = {16'b0, res_q, 2'b01};
		end else begin
			a = {rem_q, sh_q[D2_W-1]};
			b = divisor;
		end
		diff = {1'b0, a} - {2'b0, b};
		ge   = !diff[LEN2_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sq_q  <= 1'b0;
		end else if (ctl.start) begin
			sq_q <= ctl.sqrt;
			if (ctl.sqrt) begin
				cnt_q <= CNT_W'(ROOT_W);
			end else begin
				cnt_q <= CNT_W'(RATIO_W);
			end
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			res_q <= '0;
			if (ctl.sqrt) begin
				rem_q <= '0;
				sh_q  <= opnd;
			end else begin
				rem_q <= opnd[LEN2_W+7:8];
				sh_q  <= {opnd[7:0], 56'b0};
			end
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[LEN2_W-1:0] : a[LEN2_W-1:0];
			sh_q  <= sq_q ? (sh_q << 2) : (sh_q << 1);
			res_q <= {res_q[ROOT_W-2:0], ge};
		end
	end

	assign run = (cnt_q != '0);
	assign res = res_q;

endmodule

// ===== hw/rtl/ptpp_mul.sv =====
module ptpp_mul import ptpp_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== hw/rtl/ptpp_vstore.sv =====
module ptpp_vstore import ptpp_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int AW           = 6
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic signed [COORD_W-1:0] wx,
	input  logic signed [COORD_W-1:0] wy,
	input  logic [AW-1:0]             raddr,
	output logic signed [COORD_W-1:0] rx_q,
	output logic signed [COORD_W-1:0] ry_q
);

	logic [2*COORD_W-1:0] mem [MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wx, wy};
		end
		{rx_q, ry_q} <= mem[raddr];
	end

endmodule

// ===== hw/rtl/ptpp_checker.sv =====
module ptpp_checker import ptpp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [OP_W-1:0]           op,
	input logic signed [COORD_W-1:0] coord_x,
	input logic signed [COORD_W-1:0] coord_y,
	input logic                      done,
	input logic                      found,
	input logic [DIST_W-1:0]         distance,
	input logic [PROG_W-1:0]         progress
);

	logic unused_coord;
	assign unused_coord = ^{coord_x, coord_y};

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in work");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (distance == '0 && progress == '0))
		else $error("empty result carries nonzero payload");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op != OP_QUERY) |=> !done)
		else $error("result produced by a request that gives none");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_QUERY) |=> busy)
		else $error("query request did not start work");

endmodule

bind point_to_polyline_projection ptpp_checker u_ptpp_checker (.*);

// ===== sim/point_to_polyline_projection_tb.sv =====
`timescale 1ns / 1ps

module point_to_polyline_projection_tb;
	import ptpp_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int STORE_DEPTH = MAX_VERTICES_DEF;

	typedef struct {
		logic [OP_W-1:0]           op;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		bit                        drain;
	} request_t;

	typedef struct {
		logic              found;
		logic [DIST_W-1:0] distance;
		logic [PROG_W-1:0] progress;
	} projection_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [OP_W-1:0] op = OP_CLEAR;
	logic signed [COORD_W-1:0] coord_x = '0;
	logic signed [COORD_W-1:0] coord_y = '0;
	logic done;
	logic found;
	logic [DIST_W-1:0] distance;
	logic [PROG_W-1:0] progress;

	request_t pending_requests[$];
	projection_t expected_projections[$];
	longint path_x[STORE_DEPTH];
	longint path_y[STORE_DEPTH];
	int path_len = 0;
	int sent_count = 0;
	int sender_idle_pct = 33;
	int error_count = 0;

	point_to_polyline_projection dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.done(done),
		.found(found),
		.distance(distance),
		.progress(progress)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned segment_ratio(longint unsigned dot_p,
			longint unsigned len2, bit last_seg);
		longint unsigned q;
		longint unsigned r;
		if (last_seg && dot_p >= (len2 << 8))
			return RATIO_MAX;
		if (!last_seg && dot_p >= len2)
			return RATIO_ONE;
		q = dot_p / len2;
		r = dot_p % len2;
		for (int k = 0; k < FRAC_W; k++) begin
			r <<= 1;
			q <<= 1;
			if (r >= len2) begin
				r -= len2;
				q |= 1;
			end
		end
		return (q > RATIO_MAX) ? RATIO_MAX : q;
	endfunction

	function automatic projection_t project_point(longint px, longint py);
		projection_t res;
		bit hit;
		longint unsigned best_d2;
		longint unsigned best_prog;
		longint unsigned acc;
		longint dx, dy, rx, ry, dot_p, ex, ey, ratio;
		longint unsigned len2, d2, seglen, prog, root;
		hit = 0;
		best_d2 = 0;
		best_prog = 0;
		acc = 0;
		for (int i = 0; i + 1 < path_len; i++) begin
			dx = path_x[i+1] - path_x[i];
			dy = path_y[i+1] - path_y[i];
			rx = px - path_x[i];
			ry = py - path_y[i];
			len2 = dx * dx + dy * dy;
			if (len2 == 0)
				continue;
			dot_p = rx * dx + ry * dy;
			ratio = (dot_p <= 0) ? 0 : segment_ratio(dot_p, len2, i + 2 == path_len);
			ex = rx - ((ratio * dx) >>> 16);
			ey = ry - ((ratio * dy) >>> 16);
			d2 = ex * ex + ey * ey;
			seglen = floor_sqrt(len2);
			if (!hit || d2 < best_d2) begin
				hit = 1;
				best_d2 = d2;
				prog = acc + ((ratio * seglen) >> 16);
				best_prog = (prog > PROG_MAX) ? PROG_MAX : prog;
			end
			acc += seglen;
			if (acc > PROG_MAX)
				acc = PROG_MAX;
		end
		res.found = hit;
		res.distance = '0;
		res.progress = '0;
		if (hit) begin
			root = floor_sqrt(best_d2);
			res.distance = (root > DIST_MAX) ? DIST_MAX : root[DIST_W-1:0];
			res.progress = best_prog[PROG_W-1:0];
		end
		return res;
	endfunction

	task automatic apply_request(logic [OP_W-1:0] cmd, longint px, longint py);
		case (cmd)
			OP_CLEAR: begin
				path_len = 0;
			end
			OP_APPEND: begin
				if (path_len < STORE_DEPTH) begin
					path_x[path_len] = px;
					path_y[path_len] = py;
					path_len++;
				end
			end
			OP_QUERY: begin
				expected_projections = {expected_projections, project_point(px, py)};
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			op <= OP_CLEAR;
			coord_x <= '0;
			coord_y <= '0;
		end else begin
			if (start && !busy) begin
				apply_request(op, coord_x, coord_y);
				sent_count++;
			end
			if (!start || !busy) begin
				if (pending_requests.size() != 0
						&& !(pending_requests[0].drain
							&& (expected_projections.size() != 0 || busy || start))
						&& $urandom_range(99) >= sender_idle_pct) begin
					start <= 1'b1;
					op <= pending_requests[0].op;
					coord_x <= pending_requests[0].x;
					coord_y <= pending_requests[0].y;
					void'(pending_requests.pop_front());
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_projections.size() == 0) begin
				$display("%0t: result with no query waiting: found %0d distance %0d progress %0d",
					$realtime, found, distance, progress);
				error_count++;
			end else begin
				projection_t want;
				want = expected_projections.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $realtime, want.found, found);
					error_count++;
				end
				if (distance !== want.distance) begin
					$display("%0t: distance expected %0d actual %0d", $realtime,
						want.distance, distance);
					error_count++;
				end
				if (progress !== want.progress) begin
					$display("%0t: progress expected %0d actual %0d", $realtime,
						want.progress, progress);
					error_count++;
				end
			end
		end
	end

	task automatic add_request(logic [OP_W-1:0] cmd, longint px, longint py, bit drain = 0);
		request_t r;
		r.op = cmd;
		r.x = COORD_W'(px);
		r.y = COORD_W'(py);
		r.drain = drain;
		pending_requests = {pending_requests, r};
	endtask

	function automatic longint wide_coord();
		logic signed [COORD_W-1:0] v;
		v = COORD_W'($urandom);
		return v;
	endfunction

	function automatic longint near_coord(longint center, int spread);
		longint v;
		v = center + $urandom_range(2 * spread) - spread;
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v;
	endfunction

	task automatic add_random_path(bit drain);
		int n;
		int spread;
		longint cx, cy;
		n = ($urandom_range(19) == 0) ? $urandom_range(66, 63) : $urandom_range(6, 2);
		spread = ($urandom_range(3) == 0) ? 4000000 : 4096;
		cx = wide_coord() / 2;
		cy = wide_coord() / 2;
		add_request(OP_CLEAR, wide_coord(), wide_coord(), drain);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				add_request(OP_APPEND, cx, cy);
			else begin
				cx = near_coord(cx, spread);
				cy = near_coord(cy, spread);
				add_request(OP_APPEND, cx, cy);
			end
		end
		repeat ($urandom_range(5, 1)) begin
			if ($urandom_range(4) == 0)
				add_request(OP_QUERY, wide_coord(), wide_coord());
			else
				add_request(OP_QUERY, near_coord(cx, 3 * spread), near_coord(cy, 3 * spread));
		end
	endtask

	initial begin
		int random_count;
		add_request(OP_QUERY, 100, -100);
		add_request(OP_APPEND, 0, 0);
		add_request(OP_QUERY, 5, 5);
		add_request(OP_APPEND, 0, 0);
		add_request(OP_QUERY, 300, 7);
		add_request(OP_APPEND, 1024, 0);
		add_request(OP_QUERY, 512, 300);
		add_request(OP_QUERY, -500, 10);
		add_request(OP_QUERY, 5000, -3);
		add_request(OP_UNUSED, 8388607, -8388608);
		add_request(OP_QUERY, 1023, 1);
		add_request(OP_CLEAR, 0, 0);
		add_request(OP_APPEND, -8388608, -8388608);
		add_request(OP_APPEND, 8388607, 8388607);
		add_request(OP_QUERY, 8388607, -8388608);
		add_request(OP_QUERY, -8388608, 8388607);
		add_request(OP_CLEAR, -1, -1);
		add_request(OP_APPEND, 0, 0);
		add_request(OP_APPEND, 1024, 0);
		add_request(OP_APPEND, 1024, 1024);
		add_request(OP_QUERY, 2048, -1024);
		add_request(OP_QUERY, 0, 1024);

		random_count = 0;
		while (random_count < 200) begin
			if ($urandom_range(9) < 7) begin
				int before_size;
				before_size = pending_requests.size();
				add_random_path(random_count == 0 || $urandom_range(9) == 0);
				random_count += pending_requests.size() - before_size;
			end else begin
				add_request(OP_W'($urandom_range(3)), wide_coord(), wide_coord());
				random_count++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_requests.size() != 0 || start) begin
			@(posedge clk);
			if (sent_count > 90)
				sender_idle_pct = 0;
			else if (sent_count > 45)
				sender_idle_pct = 50;
		end
		while (expected_projections.size() != 0 || busy)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/ptpp_pkg.sv
hw/rtl/ptpp_iter.sv
hw/rtl/ptpp_mul.sv
hw/rtl/ptpp_vstore.sv
hw/rtl/point_to_polyline_projection.sv
hw/rtl/ptpp_checker.sv
sim/point_to_polyline_projection_tb.sv
